@@ design/qrs_pkg.sv @@
package qrs_pkg;

  localparam int OUT_WIDTH    = 34;
  localparam int STATUS_WIDTH = 2;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_TWO_ROOTS = 2'd0,
    ST_NO_REAL   = 2'd1,
    ST_LEAD_ZERO = 2'd2
  } status_t;

endpackage

@@ design/qrs_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt #(
  parameter int RW     = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int XW = 2 * RW;
  localparam int TW = RW + 3;

  logic              v      [RW];
  logic [RW-1:0]     r      [RW];
  logic [RW:0]       rm     [RW];
  logic [XW-1:0]     x      [RW];
  logic [SIDE_W-1:0] sd     [RW];
  logic              v_next [RW];
  logic [RW-1:0]     r_next [RW];
  logic [RW:0]       rm_next[RW];
  logic [XW-1:0]     x_next [RW];
  logic [SIDE_W-1:0] sd_next[RW];

  always_comb begin
    logic [RW-1:0]     r_p;
    logic [RW:0]       rm_p;
    logic [XW-1:0]     x_p;
    logic [SIDE_W-1:0] sd_p;
    logic              v_p;
    logic [TW-1:0]     acc;
    logic [TW-1:0]     trial;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        v_p  = in_valid;
        r_p  = '0;
        rm_p = '0;
        x_p  = in_rad;
        sd_p = in_side;
      end else begin
        v_p  = v[k-1];
        r_p  = r[k-1];
        rm_p = rm[k-1];
        x_p  = x[k-1];
        sd_p = sd[k-1];
      end
      acc   = {rm_p, x_p[XW-1 -: 2]};
      trial = TW'({r_p, 2'b01});
      if (acc >= trial) begin
        rm_next[k] = (RW+1)'(acc - trial);
        r_next[k]  = {r_p[RW-2:0], 1'b1};
      end else begin
        rm_next[k] = acc[RW:0];
        r_next[k]  = {r_p[RW-2:0], 1'b0};
      end
      x_next[k]  = x_p << 2;
      v_next[k]  = v_p;
      sd_next[k] = sd_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RW; k++) v[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < RW; k++) v[k] <= v_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        r[k]  <= r_next[k];
        rm[k] <= rm_next[k];
        x[k]  <= x_next[k];
        sd[k] <= sd_next[k];
      end
    end
  end

  assign out_valid = v[RW-1];
  assign out_root  = r[RW-1];
  assign out_side  = sd[RW-1];

endmodule

@@ design/qrs_div.sv @@
// Pipelined restoring divider, two dividends over one divisor, one quotient bit per stage.
module qrs_div #(
  parameter int MW     = 34,
  parameter int DW     = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MW-1:0]     in_num_p,
  input  logic [MW-1:0]     in_num_m,
  input  logic [DW-1:0]     in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [MW-1:0]     out_quo_p,
  output logic [MW-1:0]     out_quo_m,
  output logic [SIDE_W-1:0] out_side
);

  // dividend shifts out the top while quotient bits shift in at the bottom
  logic              v       [MW];
  logic [MW-1:0]     np      [MW];
  logic [MW-1:0]     nm      [MW];
  logic [DW-1:0]     rp      [MW];
  logic [DW-1:0]     rn      [MW];
  logic [DW-1:0]     d       [MW];
  logic [SIDE_W-1:0] sd      [MW];
  logic              v_next  [MW];
  logic [MW-1:0]     np_next [MW];
  logic [MW-1:0]     nm_next [MW];
  logic [DW-1:0]     rp_next [MW];
  logic [DW-1:0]     rn_next [MW];
  logic [SIDE_W-1:0] sd_next [MW];

  always_comb begin
    logic              v_p;
    logic [MW-1:0]     np_p;
    logic [MW-1:0]     nm_p;
    logic [DW-1:0]     rp_p;
    logic [DW-1:0]     rn_p;
    logic [DW-1:0]     d_p;
    logic [SIDE_W-1:0] sd_p;
    logic [DW:0]       acc_p;
    logic [DW:0]       acc_m;
    for (int k = 0; k < MW; k++) begin
      if (k == 0) begin
        v_p  = in_valid;
        np_p = in_num_p;
        nm_p = in_num_m;
        rp_p = '0;
        rn_p = '0;
        d_p  = in_den;
        sd_p = in_side;
      end else begin
        v_p  = v[k-1];
        np_p = np[k-1];
        nm_p = nm[k-1];
        rp_p = rp[k-1];
        rn_p = rn[k-1];
        d_p  = d[k-1];
        sd_p = sd[k-1];
      end
      acc_p = {rp_p, np_p[MW-1]};
      acc_m = {rn_p, nm_p[MW-1]};
      if (acc_p >= {1'b0, d_p}) begin
        rp_next[k] = DW'(acc_p - {1'b0, d_p});
        np_next[k] = {np_p[MW-2:0], 1'b1};
      end else begin
        rp_next[k] = acc_p[DW-1:0];
        np_next[k] = {np_p[MW-2:0], 1'b0};
      end
      if (acc_m >= {1'b0, d_p}) begin
        rn_next[k] = DW'(acc_m - {1'b0, d_p});
        nm_next[k] = {nm_p[MW-2:0], 1'b1};
      end else begin
        rn_next[k] = acc_m[DW-1:0];
        nm_next[k] = {nm_p[MW-2:0], 1'b0};
      end
      v_next[k]  = v_p;
      sd_next[k] = sd_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MW; k++) v[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < MW; k++) v[k] <= v_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MW; k++) begin
        np[k] <= np_next[k];
        nm[k] <= nm_next[k];
        rp[k] <= rp_next[k];
        rn[k] <= rn_next[k];
        d[k]  <= (k == 0) ? in_den : d[k-1];
        sd[k] <= sd_next[k];
      end
    end
  end

  assign out_valid = v[MW-1];
  assign out_quo_p = np[MW-1];
  assign out_quo_m = nm[MW-1];
  assign out_side  = sd[MW-1];

endmodule

@@ design/quadratic_root_solver_top.sv @@
// Pipeline: product, discriminant, COEF_WIDTH+FRAC_BITS+1 square-root stages, numerator,
// COEF_WIDTH+FRAC_BITS+2 divide stages, output register. Throughput: one item per cycle
// unless stalled; the square-root and divide pipelines each retire one bit per stage.
// The whole pipeline holds while a result waits.
// Reset (rst, synchronous) clears only the valid bits; data registers are not reset.
module quadratic_root_solver_top #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  coef_valid,
  output logic                                  coef_ready,
  input  logic signed [COEF_WIDTH-1:0]          coef_quad,
  input  logic signed [COEF_WIDTH-1:0]          coef_lin,
  input  logic signed [COEF_WIDTH-1:0]          coef_const,
  output logic                                  root_valid,
  input  logic                                  root_ready,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]  root_plus,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]  root_minus,
  output logic [qrs_pkg::STATUS_WIDTH-1:0]      status
);

  localparam int W      = COEF_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int OW     = qrs_pkg::OUT_WIDTH;
  localparam int SW_ST  = qrs_pkg::STATUS_WIDTH;
  localparam int DSW    = 2 * W + 3;          // signed discriminant
  localparam int DU     = 2 * W + 1;          // discriminant magnitude
  localparam int RW     = W + F + 1;          // square root width
  localparam int XW     = 2 * RW;             // radicand width
  localparam int NW     = W + F + 3;          // signed numerator
  localparam int MW     = NW - 1;             // numerator magnitude and quotient
  localparam int DNW    = W + 1;              // divisor 2|a|
  localparam int SQ_SIDE = SW_ST + 2 * W;
  localparam int DV_SIDE = SW_ST + 2;
  localparam int SATW   = ((MW + 1) > OW ? (MW + 1) : OW) + 1;
  localparam logic signed [SATW-1:0] SAT_HI = (SATW'(1) << (OW - 1)) - SATW'(1);
  localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);

  logic en;
  assign en         = !root_valid || root_ready;
  assign coef_ready = en;

  // stage 1: products
  logic                  s1_valid;
  logic signed [W-1:0]   s1_a;
  logic signed [W-1:0]   s1_b;
  logic signed [2*W-1:0] s1_bb;
  logic signed [2*W-1:0] s1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= coef_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a  <= coef_quad;
      s1_b  <= coef_lin;
      s1_bb <= coef_lin * coef_lin;
      s1_ac <= coef_quad * coef_const;
    end
  end

  // stage 2: discriminant and status
  logic signed [DSW-1:0] disc;
  qrs_pkg::status_t      st_next;
  logic                  s2_valid;
  logic signed [W-1:0]   s2_a;
  logic signed [W-1:0]   s2_b;
  qrs_pkg::status_t      s2_status;
  logic [XW-1:0]         s2_rad;

  assign disc = DSW'(s1_bb) - (DSW'(s1_ac) <<< 2);

  always_comb begin
    if (s1_a == '0) begin
      st_next = qrs_pkg::ST_LEAD_ZERO;
    end else if (disc < 0) begin
      st_next = qrs_pkg::ST_NO_REAL;
    end else begin
      st_next = qrs_pkg::ST_TWO_ROOTS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a      <= s1_a;
      s2_b      <= s1_b;
      s2_status <= st_next;
      s2_rad    <= (st_next == qrs_pkg::ST_TWO_ROOTS) ?
                   (XW'(disc[DU-1:0]) << (2 * F)) : '0;
    end
  end

  // square root
  logic               sq_valid;
  logic [RW-1:0]      sq_root;
  logic [SQ_SIDE-1:0] sq_side;

  qrs_sqrt #(
    .RW     (RW),
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .in_rad    (s2_rad),
    .in_side   ({s2_status, s2_a, s2_b}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 3: numerators, magnitudes and signs
  logic [SW_ST-1:0]     sq_status;
  logic signed [W-1:0]  sq_a;
  logic signed [W-1:0]  sq_b;
  logic signed [NW-1:0] nb;
  logic signed [NW-1:0] r_ext;
  logic signed [NW-1:0] n_plus;
  logic signed [NW-1:0] n_minus;
  logic signed [DNW-1:0] a_ext;
  logic [DNW-1:0]       a_mag;

  assign sq_status = sq_side[SQ_SIDE-1 -: SW_ST];
  assign sq_a      = sq_side[2*W-1 -: W];
  assign sq_b      = sq_side[W-1:0];
  assign nb        = -(NW'(sq_b) <<< F);
  assign r_ext     = NW'(sq_root);
  assign n_plus    = nb + r_ext;
  assign n_minus   = nb - r_ext;
  assign a_ext     = DNW'(sq_a);
  assign a_mag     = sq_a[W-1] ? DNW'(-a_ext) : DNW'(a_ext);

  logic             s3_valid;
  logic [MW-1:0]    s3_np;
  logic [MW-1:0]    s3_nm;
  logic [DNW-1:0]   s3_den;
  logic             s3_sp;
  logic             s3_sm;
  logic [SW_ST-1:0] s3_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_np     <= n_plus[NW-1] ? MW'(-n_plus) : MW'(n_plus);
      s3_nm     <= n_minus[NW-1] ? MW'(-n_minus) : MW'(n_minus);
      s3_den    <= {a_mag[W-1:0], 1'b0};
      s3_sp     <= n_plus[NW-1] ^ sq_a[W-1];
      s3_sm     <= n_minus[NW-1] ^ sq_a[W-1];
      s3_status <= sq_status;
    end
  end

  // divide
  logic               dv_valid;
  logic [MW-1:0]      dv_qp;
  logic [MW-1:0]      dv_qm;
  logic [DV_SIDE-1:0] dv_side;

  qrs_div #(
    .MW     (MW),
    .DW     (DNW),
    .SIDE_W (DV_SIDE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_num_p  (s3_np),
    .in_num_m  (s3_nm),
    .in_den    (s3_den),
    .in_side   ({s3_status, s3_sp, s3_sm}),
    .out_valid (dv_valid),
    .out_quo_p (dv_qp),
    .out_quo_m (dv_qm),
    .out_side  (dv_side)
  );

  function automatic logic [OW-1:0] sat_root(input logic [MW-1:0] mag, input logic neg);
    logic signed [SATW-1:0] q;
    q = SATW'(mag);
    if (neg) q = -q;
    if (q > SAT_HI) return SAT_HI[OW-1:0];
    if (q < SAT_LO) return SAT_LO[OW-1:0];
    return q[OW-1:0];
  endfunction

  logic two_roots;
  assign two_roots = (dv_side[DV_SIDE-1 -: SW_ST] == qrs_pkg::ST_TWO_ROOTS);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (en) begin
      root_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_plus  <= two_roots ? sat_root(dv_qp, dv_side[1]) : '0;
      root_minus <= two_roots ? sat_root(dv_qm, dv_side[0]) : '0;
      status     <= dv_side[DV_SIDE-1 -: SW_ST];
    end
  end

endmodule

@@ design/qrs_checker.sv @@
module qrs_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 coef_ready,
  input logic                                 root_valid,
  input logic                                 root_ready,
  input logic [qrs_pkg::OUT_WIDTH-1:0]        root_plus,
  input logic [qrs_pkg::OUT_WIDTH-1:0]        root_minus,
  input logic [qrs_pkg::STATUS_WIDTH-1:0]     status
);

  // a waiting result stalls the input side
  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root_ready |-> !coef_ready)
    else $error("input accepted while result stalled");

  // roots are zero unless two real roots were found
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    root_valid && status != qrs_pkg::ST_TWO_ROOTS |-> root_plus == '0 && root_minus == '0)
    else $error("nonzero root with non-success status");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root_ready |=> root_valid && $stable(root_plus) &&
    $stable(root_minus) && $stable(status))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !root_valid)
    else $error("result valid after reset");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
  .clk        (clk),
  .rst        (rst),
  .coef_ready (coef_ready),
  .root_valid (root_valid),
  .root_ready (root_ready),
  .root_plus  (root_plus),
  .root_minus (root_minus),
  .status     (status)
);
